>>> src/serpentine_paeth_residual_defines.svh
// Assertion macros shared by the serpentine Paeth residual RTL.
`ifndef SERPENTINE_PAETH_RESIDUAL_DEFINES_SVH
`define SERPENTINE_PAETH_RESIDUAL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/spr_pkg.sv
// Shared constants and types for the serpentine Paeth residual block.
`timescale 1ns / 1ps

package spr_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS = 11;
  localparam int COUNT_BITS = 16;
  localparam int RES_BITS   = PIXEL_BITS + 1;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RST = WIDTH_BITS'(640);
  localparam logic [COUNT_BITS-1:0] ROW_COUNT_RST = COUNT_BITS'(480);
  localparam logic [WIDTH_BITS-1:0] MAX_W         = WIDTH_BITS'(MAX_WIDTH);

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [ADDR_BITS-1:0]  col_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW_WIDTH = 1'b0,
    REG_ROW_COUNT = 1'b1
  } cfg_reg_t;

endpackage

>>> src/spr_ram.sv
// Generic simple dual-port RAM, read-first, registered read data.
`timescale 1ns / 1ps

module spr_ram #(
  parameter int WIDTH     = 16,
  parameter int DEPTH     = 1024,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // a read and a write of one address in a cycle returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/serpentine_paeth_residual.sv
// Top level: serpentine-scan Paeth residual generator with one-row line buffer.
//
// Usage:
//   in_*  : one pixel per beat, in serpentine order (row 0 left to right,
//           then alternating direction). Accepted when in_valid && !in_stall.
//   out_* : one residual per pixel, same order, with is_raw on the frame's
//           first pixel and is_last on its final one. Taken when
//           out_valid && !out_stall.
//   cfg_* : row_width (index 0) and row_count (index 1); cfg_ready is always
//           high. Write only while no beat is in flight.
// Pipeline: an accepted pixel passes the compute stage register and then the
//   output register; a stalled output can hold it in either.
// Throughput: one pixel per cycle while the output is not stalled; the line
//   buffer is read and written once per pixel on its one read and one write port.
// Reset: scan position, neighbor registers and config return to defaults
//   (640 x 480); the line buffer is not cleared and needs no sweep.
// Stall: a stalled result holds; the pixel behind it waits in the compute
//   stage, and in_stall rises only when both are occupied.
`timescale 1ns / 1ps
`include "serpentine_paeth_residual_defines.svh"

module serpentine_paeth_residual (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // pixel input
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [spr_pkg::PIXEL_BITS-1:0]          in_pixel,
  // residual output
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [spr_pkg::RES_BITS-1:0]     out_residual,
  output logic                                    out_is_raw,
  output logic                                    out_is_last,
  // config write
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [spr_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [spr_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

  import spr_pkg::*;

  // config registers
  logic [WIDTH_BITS-1:0] row_width_r;
  logic [COUNT_BITS-1:0] row_count_r;

  // scan state
  col_t                  column_index_r, column_index_nxt;
  logic [COUNT_BITS-1:0] row_index_r, row_index_nxt;
  logic                  scan_reverse_r, scan_reverse_nxt;

  // neighbors of the pixel in the compute stage
  pixel_t prev_pix_r;
  pixel_t prev_above_r;

  // compute stage
  logic   s1_valid_r;
  pixel_t s1_pix_r;
  logic   s1_raw_r, s1_row0_r, s1_col0_r, s1_last_r;

  // output register
  logic                       out_valid_r;
  logic signed [RES_BITS-1:0] out_residual_r;
  logic                       out_is_raw_r, out_is_last_r;

  logic accept, s1_adv;
  logic [WIDTH_BITS-1:0] w_eff, w_last;
  logic [COUNT_BITS-1:0] h_last;
  col_t   col_cur, x_cur;
  logic   end_row, last_cur;
  pixel_t above;

  // handshakes
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // effective geometry and scan position of the incoming pixel
  always_comb begin
    if (row_width_r == '0) begin
      w_eff = WIDTH_BITS'(1);
    end else if (row_width_r > MAX_W) begin
      w_eff = MAX_W;
    end else begin
      w_eff = row_width_r;
    end
    w_last  = w_eff - WIDTH_BITS'(1);
    h_last  = (row_count_r == '0) ? '0 : row_count_r - COUNT_BITS'(1);
    col_cur = ({1'b0, column_index_r} < w_eff) ? column_index_r : w_last[ADDR_BITS-1:0];
    x_cur   = scan_reverse_r ? (w_last[ADDR_BITS-1:0] - col_cur) : col_cur;
    end_row  = (col_cur == w_last[ADDR_BITS-1:0]);
    last_cur = end_row && (row_index_r >= h_last);
  end

  // next scan position
  always_comb begin
    column_index_nxt = col_cur + ADDR_BITS'(1);
    row_index_nxt    = row_index_r;
    scan_reverse_nxt = scan_reverse_r;
    if (last_cur) begin
      column_index_nxt = '0;
      row_index_nxt    = '0;
      scan_reverse_nxt = 1'b0;
    end else if (end_row) begin
      column_index_nxt = '0;
      row_index_nxt    = row_index_r + COUNT_BITS'(1);
      scan_reverse_nxt = !scan_reverse_r;
    end
  end

  // line buffer: read the row above and overwrite it with this pixel
  spr_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (x_cur),
    .wr_data (in_pixel),
    .rd_en   (accept),
    .rd_addr (x_cur),
    .rd_data (above)
  );

  // Paeth predictor: ties to the previous pixel in scan order, then the one above
  logic [PIXEL_BITS:0]   pa, pb;
  logic [PIXEL_BITS+1:0] pc;
  logic signed [PIXEL_BITS+2:0] pc_s;
  pixel_t paeth_pick, pred;
  logic signed [RES_BITS-1:0] res_nxt;

  always_comb begin
    pa   = (above >= prev_above_r) ? {1'b0, above - prev_above_r}
                                   : {1'b0, prev_above_r - above};
    pb   = (prev_pix_r >= prev_above_r) ? {1'b0, prev_pix_r - prev_above_r}
                                        : {1'b0, prev_above_r - prev_pix_r};
    pc_s = $signed({3'b000, prev_pix_r}) + $signed({3'b000, above})
         - $signed({2'b00, prev_above_r, 1'b0});
    pc   = pc_s[PIXEL_BITS+2] ? (PIXEL_BITS+2)'(0) - pc_s[PIXEL_BITS+1:0]
                              : pc_s[PIXEL_BITS+1:0];
    if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
      paeth_pick = prev_pix_r;
    end else if ({1'b0, pb} <= pc) begin
      paeth_pick = above;
    end else begin
      paeth_pick = prev_above_r;
    end

    if (s1_row0_r) begin
      pred = prev_pix_r;
    end else if (s1_col0_r) begin
      pred = above;
    end else begin
      pred = paeth_pick;
    end

    if (s1_raw_r) begin
      res_nxt = $signed({1'b0, s1_pix_r});
    end else begin
      res_nxt = $signed({1'b0, s1_pix_r} - {1'b0, pred});
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= ROW_WIDTH_RST;
      row_count_r    <= ROW_COUNT_RST;
      column_index_r <= '0;
      row_index_r    <= '0;
      scan_reverse_r <= 1'b0;
      prev_pix_r     <= '0;
      prev_above_r   <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_WIDTH: row_width_r <= cfg_data[WIDTH_BITS-1:0];
          REG_ROW_COUNT: row_count_r <= cfg_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        column_index_r <= column_index_nxt;
        row_index_r    <= row_index_nxt;
        scan_reverse_r <= scan_reverse_nxt;
      end
      // neighbors move on when the compute stage hands its beat off
      if (s1_adv && s1_valid_r) begin
        prev_pix_r   <= s1_pix_r;
        prev_above_r <= above;
      end
      if (s1_adv) begin
        s1_valid_r  <= accept;
        out_valid_r <= s1_valid_r;
      end else if (!s1_valid_r) begin
        // output held, compute stage empty: it still takes a beat
        s1_valid_r <= accept;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_pixel;
      s1_raw_r  <= (row_index_r == '0) && (col_cur == '0);
      s1_row0_r <= (row_index_r == '0);
      s1_col0_r <= (col_cur == '0);
      s1_last_r <= last_cur;
    end
    if (s1_adv && s1_valid_r) begin
      out_residual_r <= res_nxt;
      out_is_raw_r   <= s1_raw_r;
      out_is_last_r  <= s1_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_residual = out_residual_r;
  assign out_is_raw   = out_is_raw_r;
  assign out_is_last  = out_is_last_r;

  // checks
  `SPR_ASSERT_SAME(a_stall_full, in_stall, s1_valid_r && out_valid_r && out_stall, "in_stall without full pipe")
  `SPR_ASSERT_NEXT(a_acc_s1, accept, s1_valid_r, "accepted beat missing from compute stage")
  `SPR_ASSERT_NEXT(a_s1_out, s1_adv && s1_valid_r, out_valid_r, "compute beat lost on handoff")
  `SPR_ASSERT_NEXT(a_frame_wrap, accept && last_cur, (row_index_r == '0) && (column_index_r == '0) && !scan_reverse_r, "scan did not restart after frame end")

endmodule
